// ----- hdl/bpq_pkg.sv -----
// Package with the shared commands and status codes of the bounded priority queue.
`timescale 1ns / 1ps

package bpq_pkg;

   // Width of the reported occupancy field.
   localparam int OCC_WIDTH = 5;

   // Width of the status field and its codes.
   localparam int STATUS_WIDTH = 2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   // Request opcodes.
   localparam logic OPCODE_INSERT = 1'b0;
   localparam logic OPCODE_REMOVE = 1'b1;

   // Command broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

endpackage

// ----- hdl/bounded_priority_queue_top.sv -----
// Top level of the bounded priority queue: request decode, fill count and the cell chain.
//
//   channel   handshake        fields
//   -------   --------------   ------------------------------------------------------
//   request   start / busy     req_opcode, req_priority_req, req_payload
//   result    rsp_valid        rsp_status, rsp_out_priority, rsp_out_payload,
//                              rsp_occupancy
//
// Every item is handled by the whole chain at once: all cells compare the new priority and
// shift in the same edge, so a new item can be started in every cycle while busy is low.
// The result strobe rsp_valid rises in the cycle after the item is accepted and lasts
// one cycle. Busy is high only in the first cycle after reset.
// Reset empties the queue through the fill count; cell contents are not cleared.
// The receiver cannot stall the result.
`timescale 1ns / 1ps

module bounded_priority_queue_top #(
   parameter int DEPTH      = 16,
   parameter int PRI_WIDTH  = 8,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [PRI_WIDTH-1:0]                  req_priority_req,
   input  logic [DATA_WIDTH-1:0]                 req_payload,
   output logic                                  rsp_valid,
   output logic [bpq_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [PRI_WIDTH-1:0]                  rsp_out_priority,
   output logic [DATA_WIDTH-1:0]                 rsp_out_payload,
   output logic [bpq_pkg::OCC_WIDTH-1:0]         rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                              busy_ff;
   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     count_in;
   logic                              accept;
   logic                              full;
   logic                              empty;
   bpq_pkg::cell_op_type              cell_op;
   logic [bpq_pkg::STATUS_WIDTH-1:0]  status_in;

   logic                              valid_ff;
   logic [bpq_pkg::STATUS_WIDTH-1:0]  status_ff;
   logic [PRI_WIDTH-1:0]              out_priority_ff;
   logic [PRI_WIDTH-1:0]              out_priority_in;
   logic [DATA_WIDTH-1:0]             out_payload_ff;
   logic [DATA_WIDTH-1:0]             out_payload_in;
   logic [bpq_pkg::OCC_WIDTH-1:0]     occupancy_ff;

   logic [PRI_WIDTH-1:0]              cell_priority [DEPTH];
   logic [DATA_WIDTH-1:0]             cell_payload  [DEPTH];
   logic [DEPTH-1:0]                  cell_keeps;

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   // Decode the item into a chain command, a status and the new fill count.
   always_comb begin
      cell_op         = bpq_pkg::CELL_HOLD;
      status_in       = bpq_pkg::STATUS_OK;
      count_in        = count_ff;
      out_priority_in = '0;
      out_payload_in  = '0;
      if (req_opcode == bpq_pkg::OPCODE_INSERT) begin
         if (full) begin
            status_in = bpq_pkg::STATUS_FULL;
         end else begin
            cell_op  = bpq_pkg::CELL_INSERT;
            count_in = count_ff + CW'(1);
         end
      end else begin
         if (empty) begin
            status_in = bpq_pkg::STATUS_EMPTY;
         end else begin
            cell_op         = bpq_pkg::CELL_REMOVE;
            count_in        = count_ff - CW'(1);
            out_priority_in = cell_priority[0];
            out_payload_in  = cell_payload[0];
         end
      end
      if (!accept) begin
         cell_op  = bpq_pkg::CELL_HOLD;
         count_in = count_ff;
      end
   end

   // Control state: busy after reset, fill count and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff       <= status_in;
         out_priority_ff <= out_priority_in;
         out_payload_ff  <= out_payload_in;
         occupancy_ff    <= bpq_pkg::OCC_WIDTH'(count_in);
      end
   end

   // The chain of cells; cell 0 holds the entry served first.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  occupied;
      logic                  left_keeps;
      logic [PRI_WIDTH-1:0]  left_priority;
      logic [DATA_WIDTH-1:0] left_payload;
      logic [PRI_WIDTH-1:0]  right_priority;
      logic [DATA_WIDTH-1:0] right_payload;

      assign occupied = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keeps    = 1'b1;
         assign left_priority = '0;
         assign left_payload  = '0;
      end else begin : g_link_left
         assign left_keeps    = cell_keeps[i-1];
         assign left_priority = cell_priority[i-1];
         assign left_payload  = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_priority = cell_priority[i];
         assign right_payload  = cell_payload[i];
      end else begin : g_link_right
         assign right_priority = cell_priority[i+1];
         assign right_payload  = cell_payload[i+1];
      end

      bpq_cell #(
         .PRI_WIDTH  (PRI_WIDTH),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock          (clock),
         .cell_op        (cell_op),
         .new_priority   (req_priority_req),
         .new_payload    (req_payload),
         .occupied       (occupied),
         .left_keeps     (left_keeps),
         .left_priority  (left_priority),
         .left_payload   (left_payload),
         .right_priority (right_priority),
         .right_payload  (right_payload),
         .keeps          (cell_keeps[i]),
         .cell_priority  (cell_priority[i]),
         .cell_payload   (cell_payload[i])
      );
   end

   assign busy             = busy_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = out_priority_ff;
   assign rsp_out_payload  = out_payload_ff;
   assign rsp_occupancy    = occupancy_ff;

endmodule

// ----- hdl/bpq_cell.sv -----
// One storage cell of the sorted chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module bpq_cell #(
   parameter int PRI_WIDTH  = 8,
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  bpq_pkg::cell_op_type  cell_op,
   input  logic [PRI_WIDTH-1:0]  new_priority,
   input  logic [DATA_WIDTH-1:0] new_payload,
   input  logic                  occupied,
   input  logic                  left_keeps,
   input  logic [PRI_WIDTH-1:0]  left_priority,
   input  logic [DATA_WIDTH-1:0] left_payload,
   input  logic [PRI_WIDTH-1:0]  right_priority,
   input  logic [DATA_WIDTH-1:0] right_payload,
   output logic                  keeps,
   output logic [PRI_WIDTH-1:0]  cell_priority,
   output logic [DATA_WIDTH-1:0] cell_payload
);

   logic [PRI_WIDTH-1:0]  priority_ff;
   logic [PRI_WIDTH-1:0]  priority_in;
   logic [DATA_WIDTH-1:0] payload_ff;
   logic [DATA_WIDTH-1:0] payload_in;

   // This cell stays put on an insert when it holds an entry that is served
   // no later than the new one; equal priorities stay ahead of the newcomer.
   assign keeps = occupied && (priority_ff <= new_priority);

   // Next entry: hold, take the new item, shift toward the tail, or shift
   // toward the head on a remove.
   always_comb begin
      priority_in = priority_ff;
      payload_in  = payload_ff;
      case (cell_op)
         bpq_pkg::CELL_INSERT: begin
            if (!keeps) begin
               if (left_keeps) begin
                  priority_in = new_priority;
                  payload_in  = new_payload;
               end else begin
                  priority_in = left_priority;
                  payload_in  = left_payload;
               end
            end
         end
         bpq_pkg::CELL_REMOVE: begin
            priority_in = right_priority;
            payload_in  = right_payload;
         end
         default: begin
            priority_in = priority_ff;
            payload_in  = payload_ff;
         end
      endcase
   end

   // Entry storage; its contents are undefined until written.
   always_ff @(posedge clock) begin
      priority_ff <= priority_in;
      payload_ff  <= payload_in;
   end

   assign cell_priority = priority_ff;
   assign cell_payload  = payload_ff;

endmodule
